// ===== sv/chuf_pkg.sv =====
// Constants for the counter hash uniform source: mixing multipliers,
// finalizer multipliers and float clamp bounds. No dependencies.
package chuf_pkg;
  localparam logic [63:0] MIX_A = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_B = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C = 64'h94D049BB133111EB;
  localparam logic [63:0] FIN_1 = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] FIN_2 = 64'hC4CEB9FE1A85EC53;
  localparam logic [31:0] LO_BITS = 32'h33D6BF95;
  localparam logic [31:0] HI_BITS = 32'h3F7FFFFE;
endpackage

// ===== sv/counter_hash_uniform_float.sv =====
// Counter hash uniform source top level: seed mix, murmur3 finalizer, float build.
// Depends on chuf_pkg and chuf_mul64.
//
//  channel | ports                                   | dir
//  in      | in_valid in_stall in_counter_a/b/c      | request in
//  out     | out_valid out_stall out_uniform_bits/raw_top | request out
//  cfg     | cfg_we cfg_seed                         | seed write
//
// One request per cycle unless out_stall holds the pipeline; depth set by three
// 3-stage multiplies, the combine stage, two xorshift stages and the float stage.
// Synchronous active-low reset clears valid bits and seed.
// out_stall while a result waits freezes every stage and raises in_stall.
module counter_hash_uniform_float (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_counter_a,
  input  logic [31:0] in_counter_b,
  input  logic [31:0] in_counter_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_uniform_bits,
  output logic [23:0] out_raw_top,
  input  logic        cfg_we,
  input  logic [63:0] cfg_seed
);
  localparam int Depth = 13;

  logic [63:0] seed_r;
  logic [Depth-1:0] v_r;
  logic en;

  assign en = !(v_r[Depth-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      v_r    <= '0;
    end else begin
      if (cfg_we) seed_r <= cfg_seed;
      if (en) v_r <= {v_r[Depth-2:0], in_valid};
    end
  end

  logic [63:0] pa, pb, pc;
  logic [63:0] a_in, b_in, c_in;
  assign a_in = {32'd0, in_counter_a};
  assign b_in = {32'd0, in_counter_b};
  assign c_in = {32'd0, in_counter_c};
  chuf_mul64 u_ma (.clk, .en, .a(a_in), .k(chuf_pkg::MIX_A), .p(pa));
  chuf_mul64 u_mb (.clk, .en, .a(b_in), .k(chuf_pkg::MIX_B), .p(pb));
  chuf_mul64 u_mc (.clk, .en, .a(c_in), .k(chuf_pkg::MIX_C), .p(pc));

  // stage 4: combine and first xorshift
  logic [63:0] x1_r, x1_nxt, p1, x2_r, x2_nxt, p2, x3_r, x3_nxt;
  assign x1_nxt = seed_r ^ pa ^ pb ^ pc;
  always_ff @(posedge clk) begin
    if (en) x1_r <= x1_nxt ^ (x1_nxt >> 33);
  end

  chuf_mul64 u_f1 (.clk, .en, .a(x1_r), .k(chuf_pkg::FIN_1), .p(p1));
  assign x2_nxt = p1 ^ (p1 >> 33);
  always_ff @(posedge clk) begin
    if (en) x2_r <= x2_nxt;
  end

  chuf_mul64 u_f2 (.clk, .en, .a(x2_r), .k(chuf_pkg::FIN_2), .p(p2));
  assign x3_nxt = p2 ^ (p2 >> 33);
  always_ff @(posedge clk) begin
    if (en) x3_r <= x3_nxt;
  end

  // float build from top 24 bits
  logic [23:0] t;
  logic [25:0] m;
  logic [4:0]  p;
  logic [22:0] mant;
  logic [31:0] bits;
  logic [31:0] bits_r;
  logic [23:0] t_r;
  assign t = x3_r[63:40];

  always_comb begin
    if (!t[23]) m = {1'b0, t, 1'b1};
    else m = {1'b0, t, 1'b0} + {24'd0, t[0], 1'b0};
    p = 5'd0;
    for (int i = 1; i < 24; i++) begin
      if (m[i]) p = 5'(i);
    end
    if (m[25]) begin
      mant = 23'd0;
      p = 5'd25;
    end else if (m[24]) begin
      mant = m[23:1];
      p = 5'd24;
    end else begin
      mant = 23'(m[23:0] << (5'd23 - p));
    end
    bits = {1'b0, 8'(8'd102 + {3'd0, p}), mant};
    if (bits < chuf_pkg::LO_BITS) bits = chuf_pkg::LO_BITS;
    if (bits > chuf_pkg::HI_BITS) bits = chuf_pkg::HI_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bits_r <= bits;
      t_r    <= t;
    end
  end

  assign out_valid = v_r[Depth-1];
  assign out_uniform_bits = bits_r;
  assign out_raw_top = t_r;
endmodule

// ===== sv/chuf_mul64.sv =====
// Pipelined 64-bit by 64-bit constant multiply modulo 2^64, three stages.
// Uses no package. Low/high 32-bit split of the variable operand.
module chuf_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] k,
  output logic [63:0] p
);
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic [63:0] ll2_r;
  logic [31:0] cross_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= {32'd0, a[31:0]} * {32'd0, k[31:0]};
      lh_r    <= a[31:0] * k[63:32];
      hl_r    <= a[63:32] * k[31:0];
      ll2_r   <= ll_r;
      cross_r <= lh_r + hl_r;
      p_r     <= ll2_r + {cross_r, 32'd0};
    end
  end

  assign p = p_r;
endmodule
